// ===== rtl/core/lct_pkg.sv =====
package lct_pkg;

    localparam int MAX_DIGITS = 19;
    localparam int NUM_BITS   = 63;
    localparam int NUM_CELLS  = 19;
    localparam int CNT_W      = $clog2(NUM_BITS);
    localparam int COUNT_W    = 5;
    localparam int TYPE_W     = 2;

    localparam logic [TYPE_W-1:0] TYPE_INVALID = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_VISA    = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_AMEX    = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_MASTER  = 2'd3;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic clr;
        logic conv;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic               clr;
        logic               en;
        logic [COUNT_W-1:0] pos;
    } t_acc_ctl;

    typedef struct packed {
        logic [COUNT_W-1:0] digit_count;
        logic               luhn_ok;
        logic [TYPE_W-1:0]  brand;
    } t_result;

    // Luhn doubled digit: 2d, minus 9 when it has two decimal digits
    function automatic t_digit dbl_digit(input t_digit d);
        logic [4:0] p;
        begin
            p = {d, 1'b0};
            if (p >= 5'd10) begin
                p = p - 5'd9;
            end
            return p[3:0];
        end
    endfunction

    function automatic logic [TYPE_W-1:0] classify(
        input logic [COUNT_W-1:0] count,
        input t_digit             lead,
        input t_digit             next
    );
        logic [TYPE_W-1:0] t;
        begin
            t = TYPE_INVALID;
            if ((count == 5'd13 || count == 5'd16) && lead == 4'd4) begin
                t = TYPE_VISA;
            end else if (count == 5'd15 && lead == 4'd3 && (next == 4'd4 || next == 4'd7)) begin
                t = TYPE_AMEX;
            end else if (count == 5'd16 && lead == 4'd5 && next >= 4'd1 && next <= 4'd5) begin
                t = TYPE_MASTER;
            end
            return t;
        end
    endfunction

endpackage

// ===== rtl/core/lct_cell.sv =====
module lct_cell (
    input  logic              i_clk,
    input  lct_pkg::t_cell_ctl i_ctl,
    input  logic              i_carry,
    input  lct_pkg::t_digit   i_upper,
    output logic              o_carry,
    output lct_pkg::t_digit   o_digit
);

    lct_pkg::t_digit r_digit;
    lct_pkg::t_digit n_digit;
    lct_pkg::t_digit adj;

    // add-3 correction before each shift
    always_comb begin
        adj = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = {adj[2:0], i_carry};
        end else if (i_ctl.shift) begin
            n_digit = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = adj[3];
    assign o_digit = r_digit;

endmodule

// ===== rtl/core/lct_acc.sv =====
module lct_acc (
    input  logic              i_clk,
    input  lct_pkg::t_acc_ctl i_ctl,
    input  lct_pkg::t_digit   i_digit,
    output lct_pkg::t_result  o_result
);

    lct_pkg::t_digit                 r_sum;
    lct_pkg::t_digit                 r_lead;
    lct_pkg::t_digit                 r_next;
    lct_pkg::t_digit                 r_prev;
    logic [lct_pkg::COUNT_W-1:0]     r_count;

    lct_pkg::t_digit                 n_sum;
    lct_pkg::t_digit                 n_lead;
    lct_pkg::t_digit                 n_next;
    lct_pkg::t_digit                 n_prev;
    logic [lct_pkg::COUNT_W-1:0]     n_count;

    lct_pkg::t_digit                 val;
    logic [4:0]                      sum_raw;
    logic                            too_long;

    always_comb begin
        val     = i_ctl.pos[0] ? lct_pkg::dbl_digit(i_digit) : i_digit;
        sum_raw = {1'b0, r_sum} + {1'b0, val};
        if (sum_raw >= 5'd10) begin
            sum_raw = sum_raw - 5'd10;
        end

        n_sum   = r_sum;
        n_lead  = r_lead;
        n_next  = r_next;
        n_prev  = r_prev;
        n_count = r_count;
        if (i_ctl.clr) begin
            n_sum   = '0;
            n_lead  = '0;
            n_next  = '0;
            n_prev  = '0;
            n_count = 5'd1;
        end else if (i_ctl.en) begin
            n_sum  = sum_raw[3:0];
            n_prev = i_digit;
            if (i_digit != 4'd0) begin
                n_count = i_ctl.pos + 5'd1;
                n_lead  = i_digit;
                n_next  = r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_lead  <= n_lead;
        r_next  <= n_next;
        r_prev  <= n_prev;
        r_count <= n_count;
    end

    always_comb begin
        too_long = (r_count > lct_pkg::COUNT_W'(lct_pkg::MAX_DIGITS));
        if (too_long) begin
            o_result.digit_count = lct_pkg::COUNT_W'(lct_pkg::MAX_DIGITS);
            o_result.luhn_ok     = 1'b0;
            o_result.brand       = lct_pkg::TYPE_INVALID;
        end else begin
            o_result.digit_count = r_count;
            o_result.luhn_ok     = (r_sum == 4'd0);
            o_result.brand       = (r_sum == 4'd0) ?
                lct_pkg::classify(r_count, r_lead, r_next) : lct_pkg::TYPE_INVALID;
        end
    end

endmodule

// ===== rtl/core/luhn_card_type_check.sv =====
// Luhn mod-10 check with card brand lookup. Each word on the slave stream is
// a card number in binary; one result word comes out per input word with the
// brand, the Luhn pass flag and the decimal digit count. After acceptance a
// number goes through bit-serial binary to decimal conversion in a row of 19
// digit cells, then its digits are shifted out of that row into the Luhn
// accumulator, then the output register is loaded. One number is in work at a
// time; the next is taken the cycle after the previous one has left the row,
// even while the previous result still waits in the output register. A finished
// number whose output register is still full waits in the row and holds the
// input off until the result word is taken.
module luhn_card_type_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [62:0] card_number
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [1:0] brand, [2] luhn_ok, [7:3] digit_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int NC = lct_pkg::NUM_CELLS;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [lct_pkg::CNT_W-1:0]       r_cnt;
    logic [lct_pkg::CNT_W-1:0]       n_cnt;
    logic [lct_pkg::NUM_BITS-1:0]    r_bits;
    logic [lct_pkg::NUM_BITS-1:0]    n_bits;
    logic                            r_out_valid;
    logic                            n_out_valid;
    lct_pkg::t_result                r_out;
    lct_pkg::t_result                n_out;

    logic                            in_acc;
    logic                            out_free;
    lct_pkg::t_cell_ctl              cell_ctl;
    lct_pkg::t_acc_ctl               acc_ctl;
    lct_pkg::t_result                acc_res;

    logic            carry [NC+1];
    lct_pkg::t_digit digit [NC+1];

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign carry[0]  = r_bits[lct_pkg::NUM_BITS-1];
    assign digit[NC] = '0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        lct_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_carry (carry[g]),
            .i_upper (digit[g+1]),
            .o_carry (carry[g+1]),
            .o_digit (digit[g])
        );
    end

    lct_acc u_acc (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_digit  (digit[0]),
        .o_result (acc_res)
    );

    always_comb begin
        cell_ctl.clr   = in_acc;
        cell_ctl.conv  = (r_state == S_CONV);
        cell_ctl.shift = (r_state == S_SCAN);
        acc_ctl.clr    = in_acc;
        acc_ctl.en     = (r_state == S_SCAN);
        acc_ctl.pos    = r_cnt[lct_pkg::COUNT_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bits      = r_bits;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_bits  = i_s_axis_tdata[lct_pkg::NUM_BITS-1:0];
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bits = {r_bits[lct_pkg::NUM_BITS-2:0], 1'b0};
                if (r_cnt == lct_pkg::CNT_W'(lct_pkg::NUM_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt + lct_pkg::CNT_W'(1);
                end
            end
            S_SCAN: begin
                if (r_cnt == lct_pkg::CNT_W'(NC - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + lct_pkg::CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = acc_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_bits <= n_bits;
        r_out  <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_type_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.brand != lct_pkg::TYPE_INVALID) |-> r_out.luhn_ok)
        else $error("brand reported without Luhn pass");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.digit_count != 5'd0 &&
            r_out.digit_count <= lct_pkg::COUNT_W'(lct_pkg::MAX_DIGITS)))
        else $error("digit count out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CONV && r_cnt == '0))
        else $error("accepted word did not start conversion");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> r_out_valid)
        else $error("finished result not loaded");

endmodule
